[hw/rtl/lcuc_pkg.sv]
// Shared types and constants for the unit-cube line clipper.
// No dependencies; the divider, lerp and top modules import this package.
`timescale 1ns / 1ps

package lcuc_pkg;

   localparam int COORD_W    = 32;               // Q16.16 coordinate
   localparam int DELTA_W    = COORD_W + 1;      // end - start
   localparam int FACE_W     = COORD_W + 2;      // face numerator, exact
   localparam int MAG_W      = 32;               // magnitude of numerator / denominator
   localparam int FRAC_W     = 16;
   localparam int QUO_W      = 17;               // quotient bits kept, 0..131071
   localparam int T_W        = QUO_W + 1;        // signed face parameter
   localparam int TPOS_W     = 17;               // clip parameter 0..65536
   localparam int REM_W      = MAG_W + FRAC_W + 1;
   localparam int CH_W       = 8;
   localparam int CDELTA_W   = CH_W + 1;
   localparam int COLOR_W    = 24;
   localparam int NUM_AXES   = 3;
   localparam int NUM_FACES  = 2 * NUM_AXES;
   localparam int NUM_CH     = COLOR_W / CH_W;
   localparam int DIV_STAGES = QUO_W + 1;        // overflow check plus one stage per bit

   localparam logic [TPOS_W-1:0]        T_ONE    = TPOS_W'(65536);
   localparam logic signed [FACE_W-1:0] CUBE_MAX = FACE_W'(65536);

   typedef struct packed {
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] start_z;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
      logic [COORD_W-1:0] end_z;
      logic [COLOR_W-1:0] start_color;
      logic [COLOR_W-1:0] end_color;
   } in_item_type;

   typedef struct packed {
      logic               visible;
      logic [COORD_W-1:0] clip_start_x;
      logic [COORD_W-1:0] clip_start_y;
      logic [COORD_W-1:0] clip_start_z;
      logic [COORD_W-1:0] clip_end_x;
      logic [COORD_W-1:0] clip_end_y;
      logic [COORD_W-1:0] clip_end_z;
      logic [COLOR_W-1:0] clip_start_color;
      logic [COLOR_W-1:0] clip_end_color;
   } out_item_type;

   typedef struct packed {
      logic den_pos;
      logic den_neg;
      logic num_pos;
      logic t_neg;
   } face_flags_type;

   typedef struct packed {
      in_item_type                     item;
      face_flags_type [NUM_FACES-1:0]  flags;
   } prep_type;

endpackage

[hw/rtl/lcuc_stream_if.sv]
// Valid/ready stream channel carrying one payload struct.
// Payload type is set by the instantiating module.
`timescale 1ns / 1ps

interface lcuc_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/lcuc_delay.sv]
// Stall-aware delay line; each stage loads when its enable is high.
// Depends on nothing but the enables from the owning pipeline.
`timescale 1ns / 1ps

module lcuc_delay #(
   parameter type data_type = logic,
   parameter int  DEPTH     = 1
) (
   input  logic             clock,
   input  logic [DEPTH-1:0] en,
   input  data_type         din,
   output data_type         dout
);

   data_type stage_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         stage_ff[0] <= din;
      end
      for (int i = 1; i < DEPTH; i++) begin
         if (en[i]) begin
            stage_ff[i] <= stage_ff[i-1];
         end
      end
   end

   assign dout = stage_ff[DEPTH-1];

endmodule

[hw/rtl/lcuc_divider.sv]
// Pipelined restoring divider: (num << 16) / den, one quotient bit per stage.
// Saturates the quotient when it needs more than QUO_W bits. Uses lcuc_pkg.
`timescale 1ns / 1ps

module lcuc_divider
   import lcuc_pkg::*;
(
   input  logic                  clock,
   input  logic [DIV_STAGES-1:0] en,
   input  logic [MAG_W-1:0]      num_mag,
   input  logic [MAG_W-1:0]      den_mag,
   output logic [QUO_W-1:0]      quo
);

   logic [REM_W-1:0] rem_ff [DIV_STAGES];
   logic [MAG_W-1:0] den_ff [DIV_STAGES];
   logic [QUO_W-1:0] q_ff   [DIV_STAGES];
   logic             ovf_ff [DIV_STAGES];

   logic [REM_W-1:0] dividend;
   logic [REM_W-1:0] den_top;

   assign dividend = {1'b0, num_mag, {FRAC_W{1'b0}}};
   assign den_top  = {den_mag, {QUO_W{1'b0}}};

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rem_ff[0] <= dividend;
         den_ff[0] <= den_mag;
         q_ff[0]   <= '0;
         ovf_ff[0] <= (dividend >= den_top);
      end
   end

   for (genvar j = 1; j < DIV_STAGES; j++) begin : g_bit
      localparam int BIT = QUO_W - j;
      logic [REM_W-1:0] trial;
      logic             take;

      assign trial = REM_W'(den_ff[j-1]) << BIT;
      assign take  = (rem_ff[j-1] >= trial);

      always_ff @(posedge clock) begin
         if (en[j]) begin
            rem_ff[j] <= take ? (rem_ff[j-1] - trial) : rem_ff[j-1];
            den_ff[j] <= den_ff[j-1];
            q_ff[j]   <= q_ff[j-1] | (QUO_W'(take) << BIT);
            ovf_ff[j] <= ovf_ff[j-1];
         end
      end
   end

   assign quo = ovf_ff[DIV_STAGES-1] ? '1 : q_ff[DIV_STAGES-1];

endmodule

[hw/rtl/lcuc_lerp.sv]
// Two-stage fixed-point lerp: base + trunc(delta * t / 65536).
// Multiply stage then truncate-and-add stage. Uses lcuc_pkg.
`timescale 1ns / 1ps

module lcuc_lerp
   import lcuc_pkg::*;
#(
   parameter int BASE_W  = 32,
   parameter int DELTA_W = 33,
   parameter int RES_W   = 32
) (
   input  logic                      clock,
   input  logic                      en_mul,
   input  logic                      en_out,
   input  logic signed [BASE_W-1:0]  base,
   input  logic signed [DELTA_W-1:0] delta,
   input  logic [TPOS_W-1:0]         t,
   output logic [RES_W-1:0]          result
);

   localparam int PROD_W = DELTA_W + TPOS_W + 1;

   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [BASE_W-1:0] base_ff;
   logic signed [PROD_W-1:0] adj;
   logic signed [PROD_W-1:0] shifted;
   logic signed [PROD_W-1:0] sum;
   logic [RES_W-1:0]         result_ff;

   assign prod_in = delta * $signed({1'b0, t});

   always_ff @(posedge clock) begin
      if (en_mul) begin
         prod_ff <= prod_in;
         base_ff <= base;
      end
   end

   // bias negative products so the shift truncates toward zero
   assign adj     = prod_ff + $signed({{(PROD_W-FRAC_W){1'b0}}, {FRAC_W{prod_ff[PROD_W-1]}}});
   assign shifted = adj >>> FRAC_W;
   assign sum     = PROD_W'(base_ff) + shifted;

   always_ff @(posedge clock) begin
      if (en_out) begin
         result_ff <= sum[RES_W-1:0];
      end
   end

   assign result = result_ff;

endmodule

[hw/rtl/line_clip_unit_cube_top.sv]
// Liang-Barsky clipper of one 3D segment against the cube [-1, 1]^3.
// Stages: prep, the 18-stage radix-2 divider (overflow check plus 17 quotient bits)
// for the face parameters, then face tests, multiply and output.
// Throughput: one segment per cycle; stalls fill bubbles before backpressuring.
// Reset (synchronous, active high) clears all stage valid bits; data is not reset.
`timescale 1ns / 1ps

module line_clip_unit_cube_top
   import lcuc_pkg::*;
(
   input logic          clock,
   input logic          reset,
   lcuc_stream_if.sink   req_bus,
   lcuc_stream_if.source rsp_bus
);

   localparam int PREP      = 0;
   localparam int DIV_FIRST = PREP + 1;
   localparam int FACE      = DIV_FIRST + DIV_STAGES;
   localparam int MUL       = FACE + 1;
   localparam int OUT       = MUL + 1;
   localparam int NST       = OUT + 1;

   logic [NST-1:0] vld_ff;
   logic [NST-1:0] en;

   // ---------------- stage enables ----------------
   always_comb begin
      en[NST-1] = !vld_ff[NST-1] || rsp_bus.ready;
      for (int i = NST - 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= req_bus.valid;
         end
         for (int i = 1; i < NST; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   assign req_bus.ready = en[0];

   // ---------------- prep: face numerators, denominators, signs ----------------
   logic [COORD_W-1:0] s_in [NUM_AXES];
   logic [COORD_W-1:0] e_in [NUM_AXES];
   logic [MAG_W-1:0]   num_mag_in [NUM_FACES];
   logic [MAG_W-1:0]   den_mag_in [NUM_AXES];
   prep_type           prep_in;

   assign s_in[0] = req_bus.payload.start_x;
   assign s_in[1] = req_bus.payload.start_y;
   assign s_in[2] = req_bus.payload.start_z;
   assign e_in[0] = req_bus.payload.end_x;
   assign e_in[1] = req_bus.payload.end_y;
   assign e_in[2] = req_bus.payload.end_z;

   always_comb begin
      logic signed [DELTA_W-1:0] d;
      logic signed [DELTA_W-1:0] d_abs;
      logic signed [FACE_W-1:0]  num_lo;
      logic signed [FACE_W-1:0]  num_hi;
      logic signed [FACE_W-1:0]  lo_abs;
      logic signed [FACE_W-1:0]  hi_abs;
      logic                      d_nz;
      prep_in.item = req_bus.payload;
      for (int k = 0; k < NUM_AXES; k++) begin
         d      = DELTA_W'($signed(e_in[k])) - DELTA_W'($signed(s_in[k]));
         num_lo = -CUBE_MAX - FACE_W'($signed(s_in[k]));
         num_hi = FACE_W'($signed(s_in[k])) - CUBE_MAX;
         d_abs  = d[DELTA_W-1] ? -d : d;
         lo_abs = num_lo[FACE_W-1] ? -num_lo : num_lo;
         hi_abs = num_hi[FACE_W-1] ? -num_hi : num_hi;
         d_nz   = (d != '0);
         den_mag_in[k]       = d_abs[MAG_W-1:0];
         num_mag_in[2*k]     = lo_abs[MAG_W-1:0];
         num_mag_in[2*k + 1] = hi_abs[MAG_W-1:0];
         // low face divides by d, high face by -d
         prep_in.flags[2*k].den_pos   = !d[DELTA_W-1] && d_nz;
         prep_in.flags[2*k].den_neg   = d[DELTA_W-1];
         prep_in.flags[2*k].num_pos   = !num_lo[FACE_W-1] && (num_lo != '0);
         prep_in.flags[2*k].t_neg     = num_lo[FACE_W-1] ^ d[DELTA_W-1];
         prep_in.flags[2*k+1].den_pos = d[DELTA_W-1];
         prep_in.flags[2*k+1].den_neg = !d[DELTA_W-1] && d_nz;
         prep_in.flags[2*k+1].num_pos = !num_hi[FACE_W-1] && (num_hi != '0);
         prep_in.flags[2*k+1].t_neg   = num_hi[FACE_W-1] ^ (!d[DELTA_W-1] && d_nz);
      end
   end

   prep_type         prep_ff;
   logic [MAG_W-1:0] num_mag_ff [NUM_FACES];
   logic [MAG_W-1:0] den_mag_ff [NUM_AXES];

   always_ff @(posedge clock) begin
      if (en[PREP]) begin
         prep_ff    <= prep_in;
         num_mag_ff <= num_mag_in;
         den_mag_ff <= den_mag_in;
      end
   end

   // ---------------- divide: six face parameters ----------------
   logic [QUO_W-1:0] quo [NUM_FACES];
   prep_type         prep_dly;

   for (genvar f = 0; f < NUM_FACES; f++) begin : g_div
      lcuc_divider u_div (
         .clock   (clock),
         .en      (en[DIV_FIRST +: DIV_STAGES]),
         .num_mag (num_mag_ff[f]),
         .den_mag (den_mag_ff[f/2]),
         .quo     (quo[f])
      );
   end

   lcuc_delay #(
      .data_type (prep_type),
      .DEPTH     (DIV_STAGES)
   ) u_side_dly (
      .clock (clock),
      .en    (en[DIV_FIRST +: DIV_STAGES]),
      .din   (prep_ff),
      .dout  (prep_dly)
   );

   // ---------------- face tests in x min .. z max order ----------------
   logic                       vis_in;
   logic [TPOS_W-1:0]          te_in;
   logic [TPOS_W-1:0]          tl_in;
   logic signed [DELTA_W-1:0]  delta_in  [NUM_AXES];
   logic signed [CDELTA_W-1:0] cdelta_in [NUM_CH];
   logic [COORD_W-1:0]         s_dly [NUM_AXES];
   logic [COORD_W-1:0]         e_dly [NUM_AXES];

   assign s_dly[0] = prep_dly.item.start_x;
   assign s_dly[1] = prep_dly.item.start_y;
   assign s_dly[2] = prep_dly.item.start_z;
   assign e_dly[0] = prep_dly.item.end_x;
   assign e_dly[1] = prep_dly.item.end_y;
   assign e_dly[2] = prep_dly.item.end_z;

   always_comb begin
      logic signed [T_W-1:0] te;
      logic signed [T_W-1:0] tl;
      logic signed [T_W-1:0] mag;
      logic signed [T_W-1:0] t;
      logic                  vis;
      te  = '0;
      tl  = $signed({1'b0, T_ONE});
      vis = 1'b1;
      for (int f = 0; f < NUM_FACES; f++) begin
         mag = $signed({1'b0, quo[f]});
         t   = prep_dly.flags[f].t_neg ? -mag : mag;
         if (vis) begin
            if (prep_dly.flags[f].den_pos) begin
               if (t > tl) begin
                  vis = 1'b0;
               end else if (t > te) begin
                  te = t;
               end
            end else if (prep_dly.flags[f].den_neg) begin
               if (t < te) begin
                  vis = 1'b0;
               end else if (t < tl) begin
                  tl = t;
               end
            end else if (prep_dly.flags[f].num_pos) begin
               vis = 1'b0;
            end
         end
      end
      // rejected: t of 0 and 1 reproduce the original endpoints and colors
      vis_in = vis;
      te_in  = vis ? te[TPOS_W-1:0] : '0;
      tl_in  = vis ? tl[TPOS_W-1:0] : T_ONE;
      for (int k = 0; k < NUM_AXES; k++) begin
         delta_in[k] = DELTA_W'($signed(e_dly[k])) - DELTA_W'($signed(s_dly[k]));
      end
      for (int c = 0; c < NUM_CH; c++) begin
         cdelta_in[c] = $signed({1'b0, prep_dly.item.end_color[c*CH_W +: CH_W]})
                      - $signed({1'b0, prep_dly.item.start_color[c*CH_W +: CH_W]});
      end
   end

   logic                       face_vis_ff;
   logic [TPOS_W-1:0]          te_ff;
   logic [TPOS_W-1:0]          tl_ff;
   in_item_type                face_item_ff;
   logic signed [DELTA_W-1:0]  delta_ff  [NUM_AXES];
   logic signed [CDELTA_W-1:0] cdelta_ff [NUM_CH];

   always_ff @(posedge clock) begin
      if (en[FACE]) begin
         face_vis_ff  <= vis_in;
         te_ff        <= te_in;
         tl_ff        <= tl_in;
         face_item_ff <= prep_dly.item;
         delta_ff     <= delta_in;
         cdelta_ff    <= cdelta_in;
      end
   end

   // ---------------- interpolate endpoints and colors ----------------
   logic [COORD_W-1:0] s_face [NUM_AXES];
   logic [COORD_W-1:0] clip_s [NUM_AXES];
   logic [COORD_W-1:0] clip_e [NUM_AXES];
   logic [CH_W-1:0]    clip_sc [NUM_CH];
   logic [CH_W-1:0]    clip_ec [NUM_CH];

   assign s_face[0] = face_item_ff.start_x;
   assign s_face[1] = face_item_ff.start_y;
   assign s_face[2] = face_item_ff.start_z;

   for (genvar k = 0; k < NUM_AXES; k++) begin : g_coord
      lcuc_lerp #(.BASE_W(COORD_W), .DELTA_W(DELTA_W), .RES_W(COORD_W)) u_start (
         .clock (clock), .en_mul (en[MUL]), .en_out (en[OUT]),
         .base  ($signed(s_face[k])), .delta (delta_ff[k]), .t (te_ff),
         .result (clip_s[k])
      );
      lcuc_lerp #(.BASE_W(COORD_W), .DELTA_W(DELTA_W), .RES_W(COORD_W)) u_end (
         .clock (clock), .en_mul (en[MUL]), .en_out (en[OUT]),
         .base  ($signed(s_face[k])), .delta (delta_ff[k]), .t (tl_ff),
         .result (clip_e[k])
      );
   end

   for (genvar c = 0; c < NUM_CH; c++) begin : g_chan
      logic signed [CDELTA_W-1:0] cbase;
      assign cbase = $signed({1'b0, face_item_ff.start_color[c*CH_W +: CH_W]});

      lcuc_lerp #(.BASE_W(CDELTA_W), .DELTA_W(CDELTA_W), .RES_W(CH_W)) u_start (
         .clock (clock), .en_mul (en[MUL]), .en_out (en[OUT]),
         .base  (cbase), .delta (cdelta_ff[c]), .t (te_ff),
         .result (clip_sc[c])
      );
      lcuc_lerp #(.BASE_W(CDELTA_W), .DELTA_W(CDELTA_W), .RES_W(CH_W)) u_end (
         .clock (clock), .en_mul (en[MUL]), .en_out (en[OUT]),
         .base  (cbase), .delta (cdelta_ff[c]), .t (tl_ff),
         .result (clip_ec[c])
      );
   end

   logic vis_mul_ff;
   logic vis_out_ff;

   always_ff @(posedge clock) begin
      if (en[MUL]) begin
         vis_mul_ff <= face_vis_ff;
      end
      if (en[OUT]) begin
         vis_out_ff <= vis_mul_ff;
      end
   end

   // ---------------- result channel ----------------
   assign rsp_bus.valid                    = vld_ff[OUT];
   assign rsp_bus.payload.visible          = vis_out_ff;
   assign rsp_bus.payload.clip_start_x     = clip_s[0];
   assign rsp_bus.payload.clip_start_y     = clip_s[1];
   assign rsp_bus.payload.clip_start_z     = clip_s[2];
   assign rsp_bus.payload.clip_end_x       = clip_e[0];
   assign rsp_bus.payload.clip_end_y       = clip_e[1];
   assign rsp_bus.payload.clip_end_z       = clip_e[2];
   assign rsp_bus.payload.clip_start_color = {clip_sc[2], clip_sc[1], clip_sc[0]};
   assign rsp_bus.payload.clip_end_color   = {clip_ec[2], clip_ec[1], clip_ec[0]};

   // ---------------- checks ----------------
   a_reject_identity: assert property (@(posedge clock) disable iff (reset)
      vld_ff[FACE] && !face_vis_ff |-> (te_ff == '0) && (tl_ff == T_ONE))
      else $error("rejected segment carries clip parameters other than 0 and 1");

   a_enter_before_leave: assert property (@(posedge clock) disable iff (reset)
      vld_ff[FACE] && face_vis_ff |-> (te_ff <= tl_ff) && (tl_ff <= T_ONE))
      else $error("visible segment with entering parameter past leaving parameter");

   a_backpressure_full: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (&vld_ff))
      else $error("input stalled while the pipeline still has a bubble");

   a_stall_holds_out: assert property (@(posedge clock) disable iff (reset)
      vld_ff[OUT] && !rsp_bus.ready |=> vld_ff[OUT] && $stable(vis_out_ff))
      else $error("stalled result lost or changed");

endmodule
